@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define SLE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sle: assertion failed");
// Property that must hold on the cycle after reset is seen.
`define SLE_ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) rst |=> prop) \
    else $error("sle: reset assertion failed");
`else
`define SLE_ASSERT(lbl, clk, rst, prop)
`define SLE_ASSERT_RST(lbl, clk, rst, prop)
`endif
`endif

@@ hdl/sle_pkg.sv @@
package sle_pkg;

  // Line store geometry
  localparam int LINE_SIZE = 32;
  localparam int CNT_W     = $clog2(LINE_SIZE);

  // Payload widths
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int LEN_W  = 5;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // Control characters
  localparam logic [BYTE_W-1:0] CH_NUL = 8'd0;
  localparam logic [BYTE_W-1:0] CH_BEL = 8'd7;
  localparam logic [BYTE_W-1:0] CH_BS  = 8'd8;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'd32;
  localparam logic [BYTE_W-1:0] CH_DEL = 8'd127;

  // Command opcodes passed from front to back
  typedef logic [1:0] op_t;
  localparam op_t OP_CHAR  = 2'd0;
  localparam op_t OP_ERASE = 2'd1;
  localparam op_t OP_CR    = 2'd2;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // Command queue
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);

endpackage

@@ hdl/sle_if.sv @@
// Receive channel: one byte per transaction.
interface sle_rx_if import sle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel: echo bytes, line bytes and end markers.
interface sle_tx_if import sle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  line_length;
  logic              last;

  modport source (output valid, output out_kind, output out_byte, output line_length,
                  output last, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input line_length,
                  input last, output ready);
endinterface

@@ hdl/serial_line_editor_with_echo.sv @@
// Serial line editor with echo. Received bytes are classified on entry and
// queued (two commands deep); the back end then edits a 32-byte line store
// and sends at most one result per cycle through a registered output, so
// up to two commands can still be queued while a result waits. A printable
// byte or a bell is queued and then executed, which also loads its echo
// into the output register; an erase with echo then passes through
// ST_ERASE_SP and ST_ERASE_BS for the rest of its echo. A carriage return
// emits the optional CR/LF echo, then the stored bytes at one per cycle
// while the output is not stalled, after priming the line store read port,
// then the end marker; an empty line needs no priming. The echo_en register
// is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while the block is idle, which the block itself does not enforce.
module serial_line_editor_with_echo import sle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  sle_rx_if.sink   rx,
  sle_tx_if.source tx
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t pop_cmd;
  logic full;
  logic empty;

  sle_front u_front (
    .rx       (rx),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  sle_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (full),
    .empty    (empty)
  );

  sle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .empty       (empty),
    .cmd         (pop_cmd),
    .pop         (pop),
    .tx          (tx)
  );

endmodule

@@ hdl/sle_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/sle_front.sv @@
// Accepts received bytes and turns them into commands for the back end.
module sle_front import sle_pkg::*; (
  sle_rx_if.sink rx,
  input  logic   full,
  output logic   push,
  output cmd_t   push_cmd
);

  logic is_cmd;

  // Classify the byte; NUL and LF carry no command and are dropped here
  always_comb begin
    is_cmd        = 1'b1;
    push_cmd.data = rx.rx_byte;
    push_cmd.op   = OP_CHAR;
    priority if (rx.rx_byte == CH_NUL || rx.rx_byte == CH_LF) begin
      is_cmd = 1'b0;
    end else if (rx.rx_byte == CH_CR) begin
      push_cmd.op = OP_CR;
    end else if (rx.rx_byte == CH_BS || rx.rx_byte == CH_DEL) begin
      push_cmd.op = OP_ERASE;
    end else begin
      push_cmd.op = OP_CHAR;
    end
  end

  assign rx.ready = !full;
  assign push     = rx.valid && !full && is_cmd;

endmodule

@@ hdl/sle_cmd_fifo.sv @@
// Short command queue between front and back.
module sle_cmd_fifo import sle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  cmd_t             entry [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr;
  logic [CQ_AW-1:0] rd_ptr;
  logic [CQ_AW:0]   fill;

  assign full    = (fill == (CQ_AW + 1)'(CQ_DEPTH));
  assign empty   = (fill == '0);
  assign pop_cmd = entry[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ hdl/sle_back.sv @@
`include "assert_macros.svh"
// Executes commands: keeps the line count, writes the line store and
// sequences echo, line and end-marker results through an output register.
module sle_back import sle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        empty,
  input  cmd_t        cmd,
  output logic        pop,
  sle_tx_if.source    tx
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ERASE_SP = 3'd1;
  localparam logic [2:0] ST_ERASE_BS = 3'd2;
  localparam logic [2:0] ST_CRLF     = 3'd3;
  localparam logic [2:0] ST_LINE     = 3'd4;
  localparam logic [2:0] ST_END      = 3'd5;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             primed, primed_next;
  logic             echo_en;

  logic              out_valid, out_valid_next;
  logic [KIND_W-1:0] out_kind, out_kind_next;
  logic [BYTE_W-1:0] out_byte, out_byte_next;
  logic [LEN_W-1:0]  out_len, out_len_next;
  logic              out_last, out_last_next;

  logic              out_free;
  logic              ram_we;
  logic [CNT_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              room;

  assign out_free = !out_valid || tx.ready;
  assign pop      = (state == ST_IDLE) && !empty && out_free;
  assign room     = (count != CNT_W'(LINE_SIZE - 1));

  sle_ram #(.WIDTH(BYTE_W), .DEPTH(LINE_SIZE)) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count),
    .wdata (cmd.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Command sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    primed_next    = primed;
    ram_we         = 1'b0;
    rd_addr        = idx;
    out_valid_next = out_valid && !tx.ready;
    out_kind_next  = out_kind;
    out_byte_next  = out_byte;
    out_len_next   = out_len;
    out_last_next  = out_last;

    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          out_kind_next = KIND_ECHO;
          out_len_next  = '0;
          unique case (cmd.op)
            OP_CHAR: begin
              out_valid_next = echo_en;
              out_last_next  = 1'b1;
              if (room) begin
                ram_we        = 1'b1;
                count_next    = count + 1'b1;
                out_byte_next = cmd.data;
              end else begin
                out_byte_next = CH_BEL;
              end
            end
            OP_ERASE: begin
              if (count != '0) begin
                count_next = count - 1'b1;
                if (echo_en) begin
                  out_valid_next = 1'b1;
                  out_byte_next  = CH_BS;
                  out_last_next  = 1'b0;
                  state_next     = ST_ERASE_SP;
                end
              end
            end
            OP_CR: begin
              idx_next    = '0;
              primed_next = 1'b0;
              if (echo_en) begin
                out_valid_next = 1'b1;
                out_byte_next  = CH_CR;
                out_last_next  = 1'b0;
                state_next     = ST_CRLF;
              end else begin
                state_next = (count != '0) ? ST_LINE : ST_END;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ERASE_SP: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = CH_SP;
          state_next     = ST_ERASE_BS;
        end
      end
      ST_ERASE_BS: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = CH_BS;
          out_last_next  = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_CRLF: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = CH_LF;
          state_next     = (count != '0) ? ST_LINE : ST_END;
        end
      end
      ST_LINE: begin
        // read data is registered, so it is good in the cycle after the address settles
        primed_next = 1'b1;
        if (primed && out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = KIND_LINE;
          out_byte_next  = rd_data;
          out_last_next  = 1'b0;
          idx_next       = idx + 1'b1;
          rd_addr        = idx + 1'b1;
          if (idx + 1'b1 == count) begin
            state_next = ST_END;
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = KIND_END;
          out_byte_next  = '0;
          out_len_next   = LEN_W'(count);
          out_last_next  = 1'b1;
          count_next     = '0;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
      echo_en   <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      primed    <= primed_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        echo_en <= cfg_wr_data;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_kind <= out_kind_next;
    out_byte <= out_byte_next;
    out_len  <= out_len_next;
    out_last <= out_last_next;
  end

  assign tx.valid       = out_valid;
  assign tx.out_kind    = out_kind;
  assign tx.out_byte    = out_byte;
  assign tx.line_length = out_len;
  assign tx.last        = out_last;

  `SLE_ASSERT_RST(a_reset_idle, clk, rst, (state == ST_IDLE) && !out_valid)
  `SLE_ASSERT(a_end_is_last, clk, rst, (out_valid && out_kind == KIND_END) |-> out_last)
  `SLE_ASSERT(a_line_not_last, clk, rst, (out_valid && out_kind == KIND_LINE) |-> !out_last)
  `SLE_ASSERT(a_flush_nonempty, clk, rst, (state == ST_LINE) |-> (count != '0 && idx != count))

endmodule
